### rtl/two_group_fan_duty_controller_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the two-group fan duty controller
// Shared property wrappers, clocked on clk and disabled while in reset.
// ---------------------------------------------------------------------------
`ifndef TWO_GROUP_FAN_DUTY_CONTROLLER_DEFINES_SVH
`define TWO_GROUP_FAN_DUTY_CONTROLLER_DEFINES_SVH

// Property must hold at every clock edge outside reset.
`define TGFD_ASSERT_IMPL(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define TGFD_ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

### rtl/tgfd_pkg.sv
// ---------------------------------------------------------------------------
// tgfd_pkg
// Types, field layout and curve constants of the two-group fan controller.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tgfd_pkg;

    // Field widths
    localparam int CODE_W     = 13;
    localparam int TIME_W     = 20;
    localparam int MS_W       = 32;
    localparam int DUTY_W     = 8;
    localparam int RPM_W      = 12;
    localparam int PCT_W      = 7;
    localparam int DEG_W      = 9;

    // Divider sizing: dividend is 100*high, divisor is high+low
    localparam int DIVIDEND_W  = 27;
    localparam int DIVISOR_W   = 21;
    localparam int DIV_COUNT_W = 5;

    // Stream layout
    localparam int S_TDATA_W = 104;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 1;

    localparam int A_CODE_LSB = 0;
    localparam int B_CODE_LSB = 13;
    localparam int HIGH_LSB   = 26;
    localparam int LOW_LSB    = 46;
    localparam int NOW_LSB    = 66;

    // Register port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [MS_W-1:0] SWITCH_INTERVAL_RESET = 32'd20000;

    // Fan curve
    localparam logic [DEG_W-1:0]  CURVE_LOW_C  = 9'd20;
    localparam logic [DEG_W-1:0]  CURVE_HIGH_C = 9'd40;
    localparam logic [DUTY_W-1:0] CURVE_MIN    = 8'd100;
    localparam logic [DUTY_W-1:0] CURVE_MAX    = 8'd255;
    localparam logic [PCT_W-1:0]  PCT_FULL     = 7'd100;
    localparam logic [RPM_W-1:0]  RPM_FULL     = 12'd3000;

    // Reciprocals: x/100 = (x*5243)>>19 for x <= 25500,
    // x/17 = (x*61681)>>20 for x <= 51000
    localparam logic [12:0] RECIP_100       = 13'd5243;
    localparam int          RECIP_100_SHIFT = 19;
    localparam logic [15:0] RECIP_17        = 16'd61681;
    localparam int          RECIP_17_SHIFT  = 20;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DUTY,
        ST_RPM
    } state_t;

    typedef enum logic {
        REG_CONT_MODE       = 1'b0,
        REG_SWITCH_INTERVAL = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic            continuous_mode;
        logic [MS_W-1:0] switch_interval_ms;
    } cfg_t;

    // pct*255/100, truncated
    function automatic logic [DUTY_W-1:0] host_duty(input logic [PCT_W-1:0] pct);
        logic [14:0] scaled;
        logic [27:0] prod;
        scaled = {pct, 8'b0} - {8'b0, pct};
        prod   = {13'b0, scaled} * {15'b0, RECIP_100};
        return prod[RECIP_100_SHIFT +: DUTY_W];
    endfunction

    // Host wins over an invalid sensor, or when 16*pct exceeds the code
    function automatic logic host_wins(input logic [PCT_W-1:0]  pct,
                                       input logic [CODE_W-1:0] code,
                                       input logic              valid);
        return !valid || ({2'b0, pct, 4'b0} > code);
    endfunction

    // Linear curve over whole degrees: 100 + (deg-20)*31/4, clamped
    function automatic logic [DUTY_W-1:0] curve_duty(input logic [CODE_W-1:0] code,
                                                     input logic              valid);
        logic [DEG_W-1:0] deg;
        logic [5:0]       d6;
        logic [9:0]       step;
        logic [DUTY_W-1:0] v;
        deg  = code[CODE_W-1:4];
        d6   = deg[5:0] - 6'd20;
        step = {d6[4:0], 5'b0} - {5'b0, d6[4:0]};
        if (!valid || deg <= CURVE_LOW_C)
            v = CURVE_MIN;
        else if (deg >= CURVE_HIGH_C)
            v = CURVE_MAX;
        else
            v = CURVE_MIN + step[9:2];
        return v;
    endfunction

    // duty*3000/255 = duty*200/17, truncated
    function automatic logic [RPM_W-1:0] rpm_of(input logic [DUTY_W-1:0] duty);
        logic [15:0] x;
        logic [31:0] prod;
        x    = {1'b0, duty, 7'b0} + {2'b0, duty, 6'b0} + {5'b0, duty, 3'b0};
        prod = {16'b0, x} * {16'b0, RECIP_17};
        return prod[RECIP_17_SHIFT +: RPM_W];
    endfunction

endpackage

### rtl/tgfd_div.sv
// ---------------------------------------------------------------------------
// tgfd_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgfd_div
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [tgfd_pkg::DIVIDEND_W-1:0]     dividend,
    input  logic [tgfd_pkg::DIVISOR_W-1:0]      divisor,
    output logic                                done,
    output logic [tgfd_pkg::PCT_W-1:0]          quotient
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    logic [tgfd_pkg::DIV_COUNT_W-1:0]  count_reg, count_next;
    logic [tgfd_pkg::DIVIDEND_W-1:0]   dq_reg, dq_next;
    logic [tgfd_pkg::DIVISOR_W-1:0]    rem_reg, rem_next;
    logic [tgfd_pkg::DIVISOR_W-1:0]    dvs_reg, dvs_next;

    logic [tgfd_pkg::DIVISOR_W:0]      trial;
    logic [tgfd_pkg::DIVISOR_W:0]      diff;
    logic                              fits;
    logic                              last_step;

    assign trial     = {rem_reg, dq_reg[tgfd_pkg::DIVIDEND_W-1]};
    assign diff      = trial - {1'b0, dvs_reg};
    assign fits      = trial >= {1'b0, dvs_reg};
    assign last_step = count_reg == tgfd_pkg::DIV_COUNT_W'(tgfd_pkg::DIVIDEND_W - 1);

    always_comb
    begin
        busy_next  = busy_reg;
        count_next = count_reg;
        dq_next    = dq_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        done_next  = 1'b0;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            dq_next    = dividend;
            rem_next   = '0;
            // hold the divisor for the whole run
            dvs_next   = divisor;
        end
        else if (busy_reg)
        begin
            // shift the next dividend bit in, subtract where it fits
            dq_next    = {dq_reg[tgfd_pkg::DIVIDEND_W-2:0], fits};
            rem_next   = fits ? diff[tgfd_pkg::DIVISOR_W-1:0]
                              : trial[tgfd_pkg::DIVISOR_W-1:0];
            count_next = count_reg + 1'b1;
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    // quotient never exceeds 100, so the low bits carry it all
    assign done     = done_reg;
    assign quotient = dq_reg[tgfd_pkg::PCT_W-1:0];

endmodule

### rtl/tgfd_cfg.sv
// ---------------------------------------------------------------------------
// tgfd_cfg
// Register port: mode and switch interval, written and read over APB.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tgfd_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tgfd_pkg::PADDR_W-1:0]     paddr,
    input  logic [tgfd_pkg::PDATA_W-1:0]     pwdata,
    output logic [tgfd_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready,
    output tgfd_pkg::cfg_t                   cfg
);

    logic                        cont_mode_reg, cont_mode_next;
    logic [tgfd_pkg::MS_W-1:0]   interval_reg, interval_next;
    logic                        wr_en;
    tgfd_pkg::reg_idx_t          idx;

    // word select only; byte offset bits are not decoded
    assign idx    = tgfd_pkg::reg_idx_t'(paddr[2]);
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        cont_mode_next = cont_mode_reg;
        interval_next  = interval_reg;
        if (wr_en)
        begin
            case (idx)
                tgfd_pkg::REG_CONT_MODE:       cont_mode_next = pwdata[0];
                tgfd_pkg::REG_SWITCH_INTERVAL: interval_next  = pwdata;
                default:                       cont_mode_next = cont_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            tgfd_pkg::REG_CONT_MODE:       prdata = {31'b0, cont_mode_reg};
            tgfd_pkg::REG_SWITCH_INTERVAL: prdata = interval_reg;
            default:                       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cont_mode_reg <= 1'b0;
            interval_reg  <= tgfd_pkg::SWITCH_INTERVAL_RESET;
        end
        else
        begin
            cont_mode_reg <= cont_mode_next;
            interval_reg  <= interval_next;
        end
    end

    assign cfg.continuous_mode    = cont_mode_reg;
    assign cfg.switch_interval_ms = interval_reg;

endmodule

### rtl/two_group_fan_duty_controller.sv
// Two-group fan duty controller. Takes one poll item (two temperature codes
// with valid flags, host PWM high/low times, millisecond count) and returns
// one item with the duty and speed estimate of each fan group, the active
// group and the host duty percent. From acceptance, an item passes through the
// 27-step bit-serial divider that works out the host percent, then the percent
// register, the duty registers and the result register, where the speed
// estimate is formed as it loads. No new item is taken until the result is
// loaded and the sequencer is back in its idle state. A finished result
// waits in the output register while the next item is accepted; while it
// waits, the following item holds at its last step.
// ---------------------------------------------------------------------------
// two_group_fan_duty_controller
// Top level: poll sequencer, group switching and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "two_group_fan_duty_controller_defines.svh"

module two_group_fan_duty_controller
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // temp_a_code, temp_b_code, host_high_us, host_low_us, now_ms, zero pad
    input  logic [tgfd_pkg::S_TDATA_W-1:0]     s_tdata,
    // temp_a_valid, temp_b_valid
    input  logic [tgfd_pkg::S_TUSER_W-1:0]     s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // duty_a, duty_b, rpm_est_a, rpm_est_b, host_duty_pct, zero pad
    output logic [tgfd_pkg::M_TDATA_W-1:0]     m_tdata,
    // group_a_active
    output logic [tgfd_pkg::M_TUSER_W-1:0]     m_tuser,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tgfd_pkg::PADDR_W-1:0]       paddr,
    input  logic [tgfd_pkg::PDATA_W-1:0]       pwdata,
    output logic [tgfd_pkg::PDATA_W-1:0]       prdata,
    output logic                               pready
);

    tgfd_pkg::cfg_t   cfg;
    tgfd_pkg::state_t state_reg, state_next;

    logic in_fire;
    logic ready_int;
    logic load_out;
    logic div_done;
    logic [tgfd_pkg::PCT_W-1:0] div_quot;

    // unpacked input fields
    logic [tgfd_pkg::CODE_W-1:0]     in_code_a, in_code_b;
    logic [tgfd_pkg::TIME_W-1:0]     in_high, in_low;
    logic [tgfd_pkg::MS_W-1:0]       in_now;
    logic [tgfd_pkg::DIVIDEND_W-1:0] dividend;
    logic [tgfd_pkg::DIVISOR_W-1:0]  divisor;
    logic [tgfd_pkg::MS_W-1:0]       elapsed;
    logic                            do_switch;

    // item under work
    logic [tgfd_pkg::CODE_W-1:0] code_a_reg, code_b_reg;
    logic                        val_a_reg, val_b_reg;
    logic                        cycle_zero_reg;
    logic [tgfd_pkg::PCT_W-1:0]  pct_reg;
    logic [tgfd_pkg::DUTY_W-1:0] duty_a_reg, duty_a_next;
    logic [tgfd_pkg::DUTY_W-1:0] duty_b_reg, duty_b_next;

    // switch state
    logic                        group_sel_reg, group_sel_next;
    logic [tgfd_pkg::MS_W-1:0]   last_switch_reg, last_switch_next;

    // result register
    logic                        m_valid_reg, m_valid_next;
    logic [tgfd_pkg::DUTY_W-1:0] out_duty_a_reg, out_duty_b_reg;
    logic [tgfd_pkg::RPM_W-1:0]  out_rpm_a_reg, out_rpm_b_reg;
    logic [tgfd_pkg::PCT_W-1:0]  out_pct_reg;
    logic                        out_sel_reg;

    logic                        hw_a, hw_b;
    logic [tgfd_pkg::DUTY_W-1:0] hd, ca, cb;

    tgfd_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_code_a = s_tdata[tgfd_pkg::A_CODE_LSB +: tgfd_pkg::CODE_W];
    assign in_code_b = s_tdata[tgfd_pkg::B_CODE_LSB +: tgfd_pkg::CODE_W];
    assign in_high   = s_tdata[tgfd_pkg::HIGH_LSB +: tgfd_pkg::TIME_W];
    assign in_low    = s_tdata[tgfd_pkg::LOW_LSB +: tgfd_pkg::TIME_W];
    assign in_now    = s_tdata[tgfd_pkg::NOW_LSB +: tgfd_pkg::MS_W];

    // 100*high as shifts and adds
    assign dividend = {1'b0, in_high, 6'b0} + {2'b0, in_high, 5'b0}
                    + {5'b0, in_high, 2'b0};
    assign divisor  = {1'b0, in_high} + {1'b0, in_low};

    assign in_fire  = s_tvalid && ready_int;
    assign s_tready = ready_int;

    tgfd_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_fire),
        .dividend (dividend),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tgfd_pkg::ST_IDLE: if (in_fire) state_next = tgfd_pkg::ST_DIV;
            tgfd_pkg::ST_DIV:  if (div_done) state_next = tgfd_pkg::ST_DUTY;
            tgfd_pkg::ST_DUTY: state_next = tgfd_pkg::ST_RPM;
            tgfd_pkg::ST_RPM:  if (!m_valid_reg || m_tready) state_next = tgfd_pkg::ST_IDLE;
            default:           state_next = tgfd_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        ready_int = 1'b0;
        load_out  = 1'b0;
        case (state_reg)
            tgfd_pkg::ST_IDLE: ready_int = 1'b1;
            tgfd_pkg::ST_RPM:  load_out  = !m_valid_reg || m_tready;
            default:
            begin
                ready_int = 1'b0;
                load_out  = 1'b0;
            end
        endcase
    end

    // switch mode: alternate once the interval has gone by
    assign elapsed   = in_now - last_switch_reg;
    assign do_switch = in_fire && !cfg.continuous_mode
                       && (elapsed >= cfg.switch_interval_ms);

    always_comb
    begin
        group_sel_next   = group_sel_reg;
        last_switch_next = last_switch_reg;
        if (do_switch)
        begin
            group_sel_next   = !group_sel_reg;
            last_switch_next = in_now;
        end
    end

    // duty selection
    assign hw_a = tgfd_pkg::host_wins(pct_reg, code_a_reg, val_a_reg);
    assign hw_b = tgfd_pkg::host_wins(pct_reg, code_b_reg, val_b_reg);
    assign hd   = tgfd_pkg::host_duty(pct_reg);
    assign ca   = tgfd_pkg::curve_duty(code_a_reg, val_a_reg);
    assign cb   = tgfd_pkg::curve_duty(code_b_reg, val_b_reg);

    always_comb
    begin
        duty_a_next = duty_a_reg;
        duty_b_next = duty_b_reg;
        if (state_reg == tgfd_pkg::ST_DUTY)
        begin
            if (cfg.continuous_mode)
            begin
                // host drives both only when it beats both sensors
                duty_a_next = (hw_a && hw_b) ? hd : ca;
                duty_b_next = (hw_a && hw_b) ? hd : cb;
            end
            else if (group_sel_reg)
            begin
                duty_a_next = hw_a ? hd : ca;
                duty_b_next = '0;
            end
            else
            begin
                duty_a_next = '0;
                duty_b_next = hw_b ? hd : cb;
            end
        end
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (load_out)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= tgfd_pkg::ST_IDLE;
            group_sel_reg   <= 1'b1;
            last_switch_reg <= '0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            group_sel_reg   <= group_sel_next;
            last_switch_reg <= last_switch_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            code_a_reg     <= in_code_a;
            code_b_reg     <= in_code_b;
            val_a_reg      <= s_tuser[0];
            val_b_reg      <= s_tuser[1];
            cycle_zero_reg <= divisor == '0;
        end
        if (div_done)
            pct_reg <= cycle_zero_reg ? '0 : div_quot;
        duty_a_reg <= duty_a_next;
        duty_b_reg <= duty_b_next;
        if (load_out)
        begin
            out_duty_a_reg <= duty_a_reg;
            out_duty_b_reg <= duty_b_reg;
            out_rpm_a_reg  <= tgfd_pkg::rpm_of(duty_a_reg);
            out_rpm_b_reg  <= tgfd_pkg::rpm_of(duty_b_reg);
            out_pct_reg    <= pct_reg;
            out_sel_reg    <= group_sel_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, out_pct_reg, out_rpm_b_reg, out_rpm_a_reg,
                       out_duty_b_reg, out_duty_a_reg};
    assign m_tuser  = out_sel_reg;

    `TGFD_ASSERT_IMPL(a_pct_range, m_valid_reg |-> out_pct_reg <= tgfd_pkg::PCT_FULL,
        "host percent above 100")
    `TGFD_ASSERT_IMPL(a_rpm_range,
        m_valid_reg |-> (out_rpm_a_reg <= tgfd_pkg::RPM_FULL)
                        && (out_rpm_b_reg <= tgfd_pkg::RPM_FULL),
        "speed estimate above full scale")
    `TGFD_ASSERT_IMPL(a_sel_on_item,
        !$stable(group_sel_reg) |-> $past(in_fire) && !cfg.continuous_mode,
        "active group changed without a switch-mode item")
    `TGFD_ASSERT_IMPL(a_idle_group_off,
        m_valid_reg && !cfg.continuous_mode
            |-> (out_sel_reg ? out_duty_b_reg == '0 : out_duty_a_reg == '0),
        "inactive group driven in switch mode")
    `TGFD_ASSERT_NEVER(a_div_done_state, div_done && (state_reg != tgfd_pkg::ST_DIV),
        "divider finished outside the divide step")

endmodule

### test/two_group_fan_duty_controller_tb.sv
// ---------------------------------------------------------------------------
// Two-group fan duty controller testbench
// Feeds poll items with random pacing into the block, with the output side
// stalling on its own pattern. Each result is checked against an in-bench
// duty calculation that tracks mode, interval and the switching state.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_group_fan_duty_controller_tb;

    import tgfd_pkg::*;

    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          SETTLE_CYCLES = 40;
    localparam int          PHASE_POLLS   = 120;
    localparam int          HOLD_CYCLES   = 600;
    localparam int unsigned DUTY_FLOOR    = 100;
    localparam int unsigned DUTY_CEIL     = 255;
    localparam int unsigned CURVE_START_C = 20;
    localparam int unsigned CURVE_SPAN_C  = 20;
    localparam int unsigned RPM_SCALE     = 3000;

    typedef struct {
        logic [CODE_W-1:0] temp_a_code;
        logic              temp_a_valid;
        logic [CODE_W-1:0] temp_b_code;
        logic              temp_b_valid;
        logic [TIME_W-1:0] host_high_us;
        logic [TIME_W-1:0] host_low_us;
        logic [MS_W-1:0]   now_ms;
    } fan_poll_t;

    typedef struct {
        logic [DUTY_W-1:0] duty_a;
        logic [DUTY_W-1:0] duty_b;
        logic [RPM_W-1:0]  rpm_est_a;
        logic [RPM_W-1:0]  rpm_est_b;
        logic              group_a_active;
        logic [PCT_W-1:0]  host_duty_pct;
    } fan_result_t;

    class fan_duty_ledger;
        logic              cont_mode;
        logic [MS_W-1:0]   interval_ms;
        logic              group_a_sel;
        logic [MS_W-1:0]   last_switch_ms;
        fan_result_t       expected_duties[$];
        int                failures;
        int                results_checked;
        int                group_switches;
        int                host_overrides;

        function new();
            cont_mode       = 1'b0;
            interval_ms     = SWITCH_INTERVAL_RESET;
            group_a_sel     = 1'b1;
            last_switch_ms  = '0;
            failures        = 0;
            results_checked = 0;
            group_switches  = 0;
            host_overrides  = 0;
        endfunction

        function void write_register(reg_idx_t idx, logic [PDATA_W-1:0] value);
            case (idx)
                REG_CONT_MODE:       cont_mode = value[0];
                REG_SWITCH_INTERVAL: interval_ms = value;
                default: ;
            endcase
        endfunction

        function int unsigned host_level(int unsigned pct);
            return (pct * 255) / 100;
        endfunction

        function bit host_beats(int unsigned pct, logic [CODE_W-1:0] code, logic valid);
            return !valid || ((pct * 16) > code);
        endfunction

        function int unsigned curve_point(logic [CODE_W-1:0] code, logic valid);
            int unsigned deg;
            int unsigned v;
            deg = code >> 4;
            if (!valid || deg <= CURVE_START_C)
                return DUTY_FLOOR;
            v = DUTY_FLOOR
                + ((deg - CURVE_START_C) * (DUTY_CEIL - DUTY_FLOOR)) / CURVE_SPAN_C;
            return (v > DUTY_CEIL) ? DUTY_CEIL : v;
        endfunction

        function int unsigned speed_of(int unsigned duty);
            return (duty * RPM_SCALE) / 255;
        endfunction

        function void note_poll(fan_poll_t p);
            fan_result_t     r;
            int unsigned     hi;
            int unsigned     lo;
            int unsigned     pct;
            int unsigned     da;
            int unsigned     db;
            logic [MS_W-1:0] elapsed;
            hi  = p.host_high_us;
            lo  = p.host_low_us;
            pct = (hi + lo == 0) ? 0 : (100 * hi) / (hi + lo);
            da  = 0;
            db  = 0;
            if (cont_mode)
            begin
                if (host_beats(pct, p.temp_a_code, p.temp_a_valid) &&
                    host_beats(pct, p.temp_b_code, p.temp_b_valid))
                begin
                    da = host_level(pct);
                    db = da;
                    host_overrides++;
                end
                else
                begin
                    da = curve_point(p.temp_a_code, p.temp_a_valid);
                    db = curve_point(p.temp_b_code, p.temp_b_valid);
                end
            end
            else
            begin
                elapsed = p.now_ms - last_switch_ms;
                if (elapsed >= interval_ms)
                begin
                    last_switch_ms = p.now_ms;
                    group_a_sel    = !group_a_sel;
                    group_switches++;
                end
                if (group_a_sel)
                begin
                    if (host_beats(pct, p.temp_a_code, p.temp_a_valid))
                    begin
                        da = host_level(pct);
                        host_overrides++;
                    end
                    else
                        da = curve_point(p.temp_a_code, p.temp_a_valid);
                end
                else
                begin
                    if (host_beats(pct, p.temp_b_code, p.temp_b_valid))
                    begin
                        db = host_level(pct);
                        host_overrides++;
                    end
                    else
                        db = curve_point(p.temp_b_code, p.temp_b_valid);
                end
            end
            r.duty_a         = DUTY_W'(da);
            r.duty_b         = DUTY_W'(db);
            r.rpm_est_a      = RPM_W'(speed_of(da));
            r.rpm_est_b      = RPM_W'(speed_of(db));
            r.group_a_active = group_a_sel;
            r.host_duty_pct  = PCT_W'(pct);
            expected_duties.push_back(r);
        endfunction

        function void compare_field(string what, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                failures++;
                $display("%0t ns: %s mismatch, expected %0d, got %0d",
                         $time, what, want, got);
            end
        endfunction

        function void check_duties(fan_result_t got);
            fan_result_t want;
            if (expected_duties.size() == 0)
            begin
                failures++;
                $display("%0t ns: result with nothing pending, expected none, got duty %0d/%0d",
                         $time, got.duty_a, got.duty_b);
                return;
            end
            want = expected_duties.pop_front();
            results_checked++;
            compare_field("duty_a", want.duty_a, got.duty_a);
            compare_field("duty_b", want.duty_b, got.duty_b);
            compare_field("rpm_est_a", want.rpm_est_a, got.rpm_est_a);
            compare_field("rpm_est_b", want.rpm_est_b, got.rpm_est_b);
            compare_field("group_a_active", want.group_a_active, got.group_a_active);
            compare_field("host_duty_pct", want.host_duty_pct, got.host_duty_pct);
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // temp_a_code, temp_b_code, host_high_us, host_low_us, now_ms, zero pad
    logic [S_TDATA_W-1:0] s_tdata = '0;
    // temp_a_valid, temp_b_valid
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // duty_a, duty_b, rpm_est_a, rpm_est_b, host_duty_pct, zero pad
    logic [M_TDATA_W-1:0] m_tdata;
    // group_a_active
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    fan_duty_ledger       sb;
    fan_result_t          seen_result;
    int                   cycle_count = 0;
    int                   hold_cycles = 0;
    int                   burst_left = 0;
    int                   polls_sent = 0;
    int                   setting_phases = 0;
    int                   stall_run = 0;
    int                   longest_stall = 0;
    logic [MS_W-1:0]      poll_ms = '0;
    logic [MS_W-1:0]      cur_interval = SWITCH_INTERVAL_RESET;

    two_group_fan_duty_controller DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic fan_poll_t make_poll(logic [CODE_W-1:0] a_code, logic a_valid,
                                            logic [CODE_W-1:0] b_code, logic b_valid,
                                            logic [TIME_W-1:0] high_us,
                                            logic [TIME_W-1:0] low_us,
                                            logic [MS_W-1:0]   ms);
        fan_poll_t p;
        p.temp_a_code  = a_code;
        p.temp_a_valid = a_valid;
        p.temp_b_code  = b_code;
        p.temp_b_valid = b_valid;
        p.host_high_us = high_us;
        p.host_low_us  = low_us;
        p.now_ms       = ms;
        return p;
    endfunction

    function automatic logic [CODE_W-1:0] pick_code();
        case ($urandom_range(0, 7))
            0:       return ($urandom_range(0, 1) == 0) ? '0 : '1;
            1:       return CODE_W'($urandom_range(0, 8191));
            // mostly around the slope of the curve
            default: return CODE_W'($urandom_range(250, 700));
        endcase
    endfunction

    function fan_poll_t random_poll();
        fan_poll_t p;
        case ($urandom_range(0, 9))
            0:       poll_ms = $urandom;
            1:       ;
            2, 3, 4: poll_ms += $urandom_range(0, 3000);
            // land near the switch point
            default: poll_ms += (cur_interval > 32'h1000_0000 ? $urandom : cur_interval)
                                + $urandom_range(0, 4000) - 2000;
        endcase
        p.now_ms       = poll_ms;
        p.temp_a_code  = pick_code();
        p.temp_b_code  = pick_code();
        p.temp_a_valid = ($urandom_range(0, 9) != 0);
        p.temp_b_valid = ($urandom_range(0, 9) != 0);
        case ($urandom_range(0, 9))
            0:
            begin
                p.host_high_us = '0;
                p.host_low_us  = '0;
            end
            1:
            begin
                p.host_high_us = TIME_W'($urandom_range(0, 20'hFFFFF));
                p.host_low_us  = '0;
            end
            2:
            begin
                p.host_high_us = '0;
                p.host_low_us  = TIME_W'($urandom_range(0, 20'hFFFFF));
            end
            3, 4:
            begin
                p.host_high_us = TIME_W'($urandom_range(0, 20'hFFFFF));
                p.host_low_us  = TIME_W'($urandom_range(0, 20'hFFFFF));
            end
            default:
            begin
                p.host_high_us = TIME_W'($urandom_range(0, 1000));
                p.host_low_us  = TIME_W'($urandom_range(0, 1000));
            end
        endcase
        return p;
    endfunction

    function automatic fan_poll_t unpack_poll(logic [S_TDATA_W-1:0] d,
                                              logic [S_TUSER_W-1:0] u);
        fan_poll_t p;
        p.temp_a_code  = d[A_CODE_LSB +: CODE_W];
        p.temp_b_code  = d[B_CODE_LSB +: CODE_W];
        p.host_high_us = d[HIGH_LSB +: TIME_W];
        p.host_low_us  = d[LOW_LSB +: TIME_W];
        p.now_ms       = d[NOW_LSB +: MS_W];
        p.temp_a_valid = u[0];
        p.temp_b_valid = u[1];
        return p;
    endfunction

    task automatic send_poll(input fan_poll_t p);
        s_tdata  <= {{(S_TDATA_W - NOW_LSB - MS_W){1'b0}}, p.now_ms, p.host_low_us,
                     p.host_high_us, p.temp_b_code, p.temp_a_code};
        s_tuser  <= {p.temp_b_valid, p.temp_a_valid};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        polls_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 45))
                @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40)
                                                     : $urandom_range(0, 6);
        end
    endtask

    // Drop valid and wait until every predicted item has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.expected_duties.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_register(idx, value);
        @(posedge clk);
    endtask

    task automatic check_register(input reg_idx_t idx, input logic [PDATA_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.compare_field(idx == REG_CONT_MODE ? "continuous_mode read" : "interval read",
                         want, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_setting(input logic cont, input logic [MS_W-1:0] interval);
        settle();
        write_reg(REG_CONT_MODE, {31'b0, cont});
        write_reg(REG_SWITCH_INTERVAL, interval);
        check_register(REG_CONT_MODE, {31'b0, cont});
        check_register(REG_SWITCH_INTERVAL, interval);
        cur_interval = interval;
        setting_phases++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_poll(unpack_poll(s_tdata, s_tuser));
            if (s_tvalid && !s_tready)
            begin
                stall_run++;
                if (stall_run > longest_stall)
                    longest_stall = stall_run;
            end
            else
                stall_run = 0;
            if (m_tvalid && m_tready)
            begin
                seen_result.duty_a         = m_tdata[0 +: DUTY_W];
                seen_result.duty_b         = m_tdata[8 +: DUTY_W];
                seen_result.rpm_est_a      = m_tdata[16 +: RPM_W];
                seen_result.rpm_est_b      = m_tdata[28 +: RPM_W];
                seen_result.host_duty_pct  = m_tdata[40 +: PCT_W];
                seen_result.group_a_active = m_tuser[0];
                sb.check_duties(seen_result);
            end
        end
    end

    // Output side: stretches of steady, random, sparse and periodic readiness
    initial
    begin : result_sink
        int mode;
        int span;
        int period;
        int n;
        forever
        begin
            mode   = $urandom_range(0, 3);
            span   = $urandom_range(20, 300);
            period = $urandom_range(2, 12);
            for (n = 0; n < span; n++)
            begin
                @(posedge clk);
                if (hold_cycles > 0)
                begin
                    m_tready <= 1'b0;
                    hold_cycles--;
                end
                else
                begin
                    case (mode)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= ($urandom_range(0, 1) == 1);
                        2:       m_tready <= ($urandom_range(0, 4) == 0);
                        default: m_tready <= ((n % period) == 0);
                    endcase
                end
            end
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run timed out after %0d cycles", cycle_count);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin : stimulus
        logic [MS_W-1:0] base_ms;
        int              phase;
        int              i;
        sb = new();
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values, switch mode with group A active
        check_register(REG_CONT_MODE, '0);
        check_register(REG_SWITCH_INTERVAL, SWITCH_INTERVAL_RESET);
        send_poll(make_poll('0, 1'b1, '0, 1'b1, '0, '0, 32'd0));
        send_poll(make_poll('1, 1'b1, '1, 1'b1, '1, '0, 32'd19999));
        // interval reached: switch to B, invalid B with a zero host cycle
        send_poll(make_poll(13'd335, 1'b1, 13'd336, 1'b0, '0, '0, 32'd20000));
        send_poll(make_poll(13'd335, 1'b1, 13'd336, 1'b1, 20'd1, 20'd1, 32'd25000));
        // host percent equal to the temperature does not win
        send_poll(make_poll(13'd800, 1'b1, 13'd800, 1'b1, 20'd500, 20'd500, 32'd30000));
        send_poll(make_poll(13'd799, 1'b1, 13'd799, 1'b1, 20'd500, 20'd500, 32'd39999));
        send_poll(make_poll('0, 1'b0, '1, 1'b1, '1, '1, 32'd40000));
        // elapsed time with the millisecond count at its largest value
        send_poll(make_poll(13'd336, 1'b1, 13'd639, 1'b1, '0, '1, 32'hFFFF_FFFF));

        apply_setting(1'b1, SWITCH_INTERVAL_RESET);
        send_poll(make_poll('0, 1'b0, '0, 1'b0, '0, '0, 32'd5));
        send_poll(make_poll('0, 1'b0, 13'd500, 1'b1, '0, '0, 32'd6));
        send_poll(make_poll(13'd320, 1'b1, 13'd639, 1'b1, 20'd99, 20'd1, 32'd7));
        send_poll(make_poll('1, 1'b1, '0, 1'b1, 20'd1, '1, 32'd8));
        send_poll(make_poll(13'd352, 1'b1, 13'd624, 1'b1, '1, '1, 32'd9));

        // zero interval toggles on every item
        apply_setting(1'b0, '0);
        send_poll(make_poll(13'd400, 1'b1, 13'd600, 1'b1, 20'd30, 20'd70, 32'd100));
        send_poll(make_poll(13'd400, 1'b1, 13'd600, 1'b1, 20'd30, 20'd70, 32'd100));
        send_poll(make_poll(13'd700, 1'b1, 13'd300, 1'b0, 20'd10, 20'd90, 32'd101));

        // widest interval: only an elapsed count of all ones switches
        apply_setting(1'b0, '1);
        base_ms = sb.last_switch_ms;
        send_poll(make_poll(13'd450, 1'b1, 13'd450, 1'b1, 20'd3, 20'd7, base_ms + 32'd5));
        send_poll(make_poll(13'd450, 1'b1, 13'd450, 1'b1, 20'd3, 20'd7, base_ms - 32'd1));

        for (phase = 0; phase < 7; phase++)
        begin
            case (phase)
                0:       apply_setting(1'b0, SWITCH_INTERVAL_RESET);
                1:       apply_setting(1'b1, SWITCH_INTERVAL_RESET);
                2:       apply_setting(1'b0, 32'd10000);
                3:       apply_setting(1'b0, '0);
                4:       apply_setting(1'b1, '1);
                5:       apply_setting(1'b0, $urandom_range(10000, 200000));
                default: apply_setting(1'b0, 32'd1);
            endcase
            poll_ms = sb.last_switch_ms;
            for (i = 0; i < PHASE_POLLS; i++)
            begin
                // hold the output off while polls keep coming, so the input backs up
                if (phase == 2 && i == 8)
                begin
                    hold_cycles = HOLD_CYCLES;
                    burst_left  = 60;
                end
                send_poll(random_poll());
            end
        end
        settle();

        $display("Sent %0d polls over %0d register settings; %0d results checked, %0d switches",
                 polls_sent, setting_phases, sb.results_checked, sb.group_switches);
        $display("Host duty took over %0d times; longest input back-pressure %0d cycles",
                 sb.host_overrides, longest_stall);
        if (sb.failures == 0 && sb.expected_duties.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### two_group_fan_duty_controller.f
+incdir+rtl
rtl/tgfd_pkg.sv
rtl/tgfd_div.sv
rtl/tgfd_cfg.sv
rtl/two_group_fan_duty_controller.sv
test/two_group_fan_duty_controller_tb.sv
